>>> rtl/mfna_pkg.sv
// ----------------------------------------------------------------------------
// mfna_pkg: shared widths, constants and types
// Widths of the face geometry pipeline and the side-band records that travel
// alongside the long square-root and division sections.
// ----------------------------------------------------------------------------
package mfna_pkg;

    localparam int COORD_W   = 32;             // Q16.16 coordinate
    localparam int EDGE_W    = 33;             // edge vector component
    localparam int PROD_W    = 66;             // edge product
    localparam int MAG_W     = 66;             // cross-product magnitude
    localparam int RED_W     = 31;             // reduced magnitude
    localparam int SQ_W      = 62;             // square of a reduced magnitude
    localparam int Q_W       = 64;             // sum of squares
    localparam int LEN_W     = 32;             // integer square root
    localparam int NORM_W    = 18;             // Q1.16 normal component
    localparam int QUOT_W    = 17;             // normal magnitude
    localparam int AREA_W    = 52;
    localparam int SHIFT_W   = 6;              // reduction shift, up to 35
    localparam int ML_W      = 7;              // bit length, up to 66
    localparam int CHUNK_W   = 11;
    localparam int N_CHUNK   = 6;
    localparam int POS_W     = 4;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;
    localparam int ASH_W     = LEN_W + 35;     // length shifted up by s
    localparam int CSUM_W    = 34;             // sum of three coordinates
    localparam int CMAG_W    = 33;
    localparam int RECIP_W   = 34;
    localparam int CPROD_W   = CMAG_W + RECIP_W;
    // ceil(2^35 / 3): exact floor division by three below 2^35
    localparam logic [RECIP_W-1:0] THIRD_RECIP = 34'd11453246123;
    localparam int THIRD_SHIFT = 35;
    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    typedef struct packed {
        logic                      is_tri;
        logic                      degen;
        logic [SHIFT_W-1:0]        s;
        logic [2:0]                neg;
        logic [2:0][RED_W-1:0]     r;
        logic [2:0][COORD_W-1:0]   centroid;
    } t_side;

    typedef struct packed {
        logic                      degen;
        logic [2:0][COORD_W-1:0]   centroid;
    } t_tail;

endpackage

>>> rtl/mfna_delay.sv
// ----------------------------------------------------------------------------
// mfna_delay: fixed-length register delay line
// Carries side-band data alongside a pipeline section of equal length.
// ----------------------------------------------------------------------------
module mfna_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_data;
        for (int k = 1; k < DEPTH; k++) begin
            r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

>>> rtl/mfna_cross_lane.sv
// ----------------------------------------------------------------------------
// mfna_cross_lane: one cross-product component
// Forms a*b - c*d exactly and returns its magnitude and sign, two stages.
// ----------------------------------------------------------------------------
module mfna_cross_lane
    import mfna_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [EDGE_W-1:0] i_a,
    input  logic signed [EDGE_W-1:0] i_b,
    input  logic signed [EDGE_W-1:0] i_c,
    input  logic signed [EDGE_W-1:0] i_d,
    output logic [MAG_W-1:0]         o_mag,
    output logic                     o_neg
);

    logic signed [PROD_W-1:0] r_ab;
    logic signed [PROD_W-1:0] r_cd;
    logic signed [PROD_W:0]   w_diff;
    logic signed [PROD_W:0]   w_abs;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;

    assign w_diff = {r_ab[PROD_W-1], r_ab} - {r_cd[PROD_W-1], r_cd};
    assign w_abs  = w_diff[PROD_W] ? -w_diff : w_diff;

    always_ff @(posedge i_clk) begin
        r_ab  <= PROD_W'(i_a) * PROD_W'(i_b);
        r_cd  <= PROD_W'(i_c) * PROD_W'(i_d);
        r_mag <= w_abs[MAG_W-1:0];
        r_neg <= w_diff[PROD_W];
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;

endmodule

>>> rtl/mfna_isqrt.sv
// ----------------------------------------------------------------------------
// mfna_isqrt: pipelined integer square root
// One root bit per stage, most significant first; 32 stages.
// ----------------------------------------------------------------------------
module mfna_isqrt
    import mfna_pkg::*;
(
    input  logic             i_clk,
    input  logic [Q_W-1:0]   i_q,
    output logic [LEN_W-1:0] o_len
);

    logic [Q_W-1:0]   r_rem [SQRT_STEPS];
    logic [LEN_W-1:0] r_res [SQRT_STEPS];

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
        localparam int K = SQRT_STEPS - 1 - g;
        logic [Q_W-1:0]   w_rem_in;
        logic [LEN_W-1:0] w_res_in;
        logic [Q_W+1:0]   w_trial;
        logic [Q_W+1:0]   w_left;
        logic             w_take;

        if (g == 0) begin : g_first
            assign w_rem_in = i_q;
            assign w_res_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[g-1];
            assign w_res_in = r_res[g-1];
        end

        always_comb begin
            w_trial = ((Q_W+2)'(w_res_in) << (K + 1)) + ((Q_W+2)'(1) << (2 * K));
            w_take  = {2'b00, w_rem_in} >= w_trial;
            w_left  = {2'b00, w_rem_in} - w_trial;
        end

        always_ff @(posedge i_clk) begin
            if (w_take) begin
                r_rem[g] <= w_left[Q_W-1:0];
                r_res[g] <= w_res_in | (LEN_W'(1) << K);
            end else begin
                r_rem[g] <= w_rem_in;
                r_res[g] <= w_res_in;
            end
        end
    end

    assign o_len = r_res[SQRT_STEPS-1];

endmodule

>>> rtl/mfna_div_lane.sv
// ----------------------------------------------------------------------------
// mfna_div_lane: normal component by restoring division
// Computes sign * floor(r * 2^16 / len), one quotient bit per stage.
// ----------------------------------------------------------------------------
module mfna_div_lane
    import mfna_pkg::*;
(
    input  logic                     i_clk,
    input  logic [RED_W-1:0]         i_r,
    input  logic [LEN_W-1:0]         i_len,
    input  logic                     i_neg,
    output logic signed [NORM_W-1:0] o_normal
);

    logic [LEN_W-1:0]  r_rem [DIV_STEPS];
    logic [LEN_W-1:0]  r_len [DIV_STEPS];
    logic [QUOT_W-1:0] r_q   [DIV_STEPS];
    logic              r_neg [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        localparam int BIT = DIV_STEPS - 1 - g;
        logic [LEN_W:0]    w_rem_in;
        logic [LEN_W-1:0]  w_len_in;
        logic [QUOT_W-1:0] w_q_in;
        logic              w_neg_in;
        logic              w_take;
        logic [LEN_W:0]    w_left;

        if (g == 0) begin : g_first
            // r never exceeds len, so the top bit is taken without a shift
            assign w_rem_in = (LEN_W+1)'(i_r);
            assign w_len_in = i_len;
            assign w_q_in   = '0;
            assign w_neg_in = i_neg;
        end else begin : g_next
            assign w_rem_in = {r_rem[g-1], 1'b0};
            assign w_len_in = r_len[g-1];
            assign w_q_in   = r_q[g-1];
            assign w_neg_in = r_neg[g-1];
        end

        always_comb begin
            w_take = w_rem_in >= {1'b0, w_len_in};
            w_left = w_rem_in - {1'b0, w_len_in};
        end

        always_ff @(posedge i_clk) begin
            r_rem[g] <= w_take ? w_left[LEN_W-1:0] : w_rem_in[LEN_W-1:0];
            r_q[g]   <= w_take ? (w_q_in | (QUOT_W'(1) << BIT)) : w_q_in;
            r_len[g] <= w_len_in;
            r_neg[g] <= w_neg_in;
        end
    end

    assign o_normal = r_neg[DIV_STEPS-1] ? -$signed({1'b0, r_q[DIV_STEPS-1]})
                                         :  $signed({1'b0, r_q[DIV_STEPS-1]});

endmodule

>>> rtl/mesh_face_normal_area.sv
// ----------------------------------------------------------------------------
// mesh_face_normal_area: unit normal, area and centroid of a mesh face
// Three cross-product lanes, a shared length stage with square root, and
// three division lanes for the normal components.
//
//   channel   handshake        payload
//   -------   --------------   ---------------------------------------------
//   face in   start / busy     i_ax..i_cz, i_is_triangle
//   result    o_valid strobe   o_normal_x/y/z, o_face_area, o_centroid_x/y/z,
//                              o_degenerate
//
// One face is taken every cycle; busy stays low.
// Each result passes through the 32-stage square root followed by the
// 17-stage normal division before it leaves.
// Reset clears the valid pipeline only; no clearing pass is needed.
// The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module mesh_face_normal_area
    import mfna_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_ax,
    input  logic signed [COORD_W-1:0] i_ay,
    input  logic signed [COORD_W-1:0] i_az,
    input  logic signed [COORD_W-1:0] i_bx,
    input  logic signed [COORD_W-1:0] i_by,
    input  logic signed [COORD_W-1:0] i_bz,
    input  logic signed [COORD_W-1:0] i_cx,
    input  logic signed [COORD_W-1:0] i_cy,
    input  logic signed [COORD_W-1:0] i_cz,
    input  logic                      i_is_triangle,
    output logic                      o_valid,
    output logic signed [NORM_W-1:0]  o_normal_x,
    output logic signed [NORM_W-1:0]  o_normal_y,
    output logic signed [NORM_W-1:0]  o_normal_z,
    output logic [AREA_W-1:0]         o_face_area,
    output logic signed [COORD_W-1:0] o_centroid_x,
    output logic signed [COORD_W-1:0] o_centroid_y,
    output logic signed [COORD_W-1:0] o_centroid_z,
    output logic                      o_degenerate
);

    localparam int LAT = 58;

    logic [LAT-1:0] r_vld;

    logic signed [COORD_W-1:0] w_a [3];
    logic signed [COORD_W-1:0] w_b [3];
    logic signed [COORD_W-1:0] w_c [3];
    logic signed [CSUM_W-1:0]  w_sum [3];

    // stage 1: edges and centroid magnitudes
    logic signed [EDGE_W-1:0] r_s1_e1 [3];
    logic signed [EDGE_W-1:0] r_s1_e2 [3];
    logic [CMAG_W-1:0]        r_s1_cmag [3];
    logic [2:0]               r_s1_cneg;
    logic                     r_s1_tri;
    // stages 2 and 3: centroid divide by three
    logic [CPROD_W-1:0]       r_s2_cprod [3];
    logic [2:0]               r_s2_cneg;
    logic                     r_s2_tri;
    logic [COORD_W-1:0]       r_s3_cen [3];
    logic                     r_s3_tri;
    logic [COORD_W-1:0]       w_cquo [3];
    logic [MAG_W-1:0]         w_mag [3];
    logic [2:0]               w_neg;
    // stage 4: chunked leading-one search
    logic [MAG_W-1:0]         w_or;
    logic [N_CHUNK-1:0]       n_nz;
    logic [POS_W-1:0]         n_pos [N_CHUNK];
    logic [N_CHUNK-1:0]       r_s4_nz;
    logic [POS_W-1:0]         r_s4_pos [N_CHUNK];
    logic [MAG_W-1:0]         r_s4_mag [3];
    logic [2:0]               r_s4_neg;
    logic [COORD_W-1:0]       r_s4_cen [3];
    logic                     r_s4_tri;
    // stage 5: bit length
    logic [ML_W-1:0]          n_ml;
    logic [ML_W-1:0]          r_s5_ml;
    logic [MAG_W-1:0]         r_s5_mag [3];
    logic [2:0]               r_s5_neg;
    logic [COORD_W-1:0]       r_s5_cen [3];
    logic                     r_s5_tri;
    // stage 6: reduction shift
    logic [SHIFT_W-1:0]       w_s;
    logic [RED_W-1:0]         r_s6_r [3];
    logic [SHIFT_W-1:0]       r_s6_s;
    logic                     r_s6_degen;
    logic [2:0]               r_s6_neg;
    logic [COORD_W-1:0]       r_s6_cen [3];
    logic                     r_s6_tri;
    // stages 7 and 8: sum of squares
    logic [SQ_W-1:0]          r_s7_sq [3];
    logic [Q_W-1:0]           r_s8_q;

    logic [LEN_W-1:0]         w_len;
    t_side                    w_side6;
    t_side                    w_side40;
    t_tail                    w_tail40;
    t_tail                    w_tail57;

    logic [ASH_W-1:0]         r_a1;
    logic [4:0]               r_a1_sh;
    logic [ASH_W-1:0]         w_a2;
    logic [AREA_W-1:0]        r_a2;
    logic [AREA_W-1:0]        w_area57;
    logic signed [NORM_W-1:0] w_nrm [3];

    logic signed [NORM_W-1:0]  r_out_nx;
    logic signed [NORM_W-1:0]  r_out_ny;
    logic signed [NORM_W-1:0]  r_out_nz;
    logic [AREA_W-1:0]         r_out_area;
    logic signed [COORD_W-1:0] r_out_cx;
    logic signed [COORD_W-1:0] r_out_cy;
    logic signed [COORD_W-1:0] r_out_cz;
    logic                      r_out_degen;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    assign w_a[0] = i_ax;
    assign w_a[1] = i_ay;
    assign w_a[2] = i_az;
    assign w_b[0] = i_bx;
    assign w_b[1] = i_by;
    assign w_b[2] = i_bz;
    assign w_c[0] = i_cx;
    assign w_c[1] = i_cy;
    assign w_c[2] = i_cz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = CSUM_W'(w_a[i]) + CSUM_W'(w_b[i]) + CSUM_W'(w_c[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s1_e1[i]   <= EDGE_W'(w_b[i]) - EDGE_W'(w_a[i]);
            r_s1_e2[i]   <= EDGE_W'(w_c[i]) - EDGE_W'(w_a[i]);
            r_s1_cmag[i] <= w_sum[i][CSUM_W-1] ? CMAG_W'(-w_sum[i]) : CMAG_W'(w_sum[i]);
            r_s1_cneg[i] <= w_sum[i][CSUM_W-1];
        end
        r_s1_tri <= i_is_triangle;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_cquo[i] = COORD_W'(r_s2_cprod[i] >> THIRD_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s2_cprod[i] <= CPROD_W'(r_s1_cmag[i]) * CPROD_W'(THIRD_RECIP);
            r_s3_cen[i]   <= r_s2_cneg[i] ? -w_cquo[i] : w_cquo[i];
        end
        r_s2_cneg <= r_s1_cneg;
        r_s2_tri  <= r_s1_tri;
        r_s3_tri  <= r_s2_tri;
    end

    mfna_cross_lane u_lane_x (
        .i_clk (i_clk),
        .i_a   (r_s1_e1[1]), .i_b (r_s1_e2[2]),
        .i_c   (r_s1_e1[2]), .i_d (r_s1_e2[1]),
        .o_mag (w_mag[0]),   .o_neg (w_neg[0])
    );

    mfna_cross_lane u_lane_y (
        .i_clk (i_clk),
        .i_a   (r_s1_e1[2]), .i_b (r_s1_e2[0]),
        .i_c   (r_s1_e1[0]), .i_d (r_s1_e2[2]),
        .o_mag (w_mag[1]),   .o_neg (w_neg[1])
    );

    mfna_cross_lane u_lane_z (
        .i_clk (i_clk),
        .i_a   (r_s1_e1[0]), .i_b (r_s1_e2[1]),
        .i_c   (r_s1_e1[1]), .i_d (r_s1_e2[0]),
        .o_mag (w_mag[2]),   .o_neg (w_neg[2])
    );

    // merge: largest bit length over the three lanes, one chunk at a time
    always_comb begin
        w_or = w_mag[0] | w_mag[1] | w_mag[2];
        for (int j = 0; j < N_CHUNK; j++) begin
            n_nz[j]  = |w_or[j*CHUNK_W +: CHUNK_W];
            n_pos[j] = '0;
            for (int b = 0; b < CHUNK_W; b++) begin
                if (w_or[j*CHUNK_W + b]) begin
                    n_pos[j] = POS_W'(b + 1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_nz <= n_nz;
        for (int j = 0; j < N_CHUNK; j++) begin
            r_s4_pos[j] <= n_pos[j];
        end
        for (int i = 0; i < 3; i++) begin
            r_s4_mag[i] <= w_mag[i];
            r_s4_cen[i] <= r_s3_cen[i];
        end
        r_s4_neg <= w_neg;
        r_s4_tri <= r_s3_tri;
    end

    always_comb begin
        n_ml = '0;
        for (int j = 0; j < N_CHUNK; j++) begin
            if (r_s4_nz[j]) begin
                n_ml = ML_W'(j * CHUNK_W) + ML_W'(r_s4_pos[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_ml <= n_ml;
        for (int i = 0; i < 3; i++) begin
            r_s5_mag[i] <= r_s4_mag[i];
            r_s5_cen[i] <= r_s4_cen[i];
        end
        r_s5_neg <= r_s4_neg;
        r_s5_tri <= r_s4_tri;
    end

    assign w_s = (r_s5_ml > ML_W'(RED_W)) ? SHIFT_W'(r_s5_ml - ML_W'(RED_W)) : '0;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s6_r[i]   <= RED_W'(r_s5_mag[i] >> w_s);
            r_s6_cen[i] <= r_s5_cen[i];
        end
        r_s6_s     <= w_s;
        r_s6_degen <= (r_s5_ml == '0);
        r_s6_neg   <= r_s5_neg;
        r_s6_tri   <= r_s5_tri;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s7_sq[i] <= SQ_W'(r_s6_r[i]) * SQ_W'(r_s6_r[i]);
        end
        r_s8_q <= Q_W'(r_s7_sq[0]) + Q_W'(r_s7_sq[1]) + Q_W'(r_s7_sq[2]);
    end

    mfna_isqrt u_isqrt (
        .i_clk (i_clk),
        .i_q   (r_s8_q),
        .o_len (w_len)
    );

    always_comb begin
        w_side6.is_tri = r_s6_tri;
        w_side6.degen  = r_s6_degen;
        w_side6.s      = r_s6_s;
        w_side6.neg    = r_s6_neg;
        for (int i = 0; i < 3; i++) begin
            w_side6.r[i]        = r_s6_r[i];
            w_side6.centroid[i] = r_s6_cen[i];
        end
    end

    // hold side data across the squares and the root
    mfna_delay #(.WIDTH($bits(t_side)), .DEPTH(2 + SQRT_STEPS)) u_side_dly (
        .i_clk  (i_clk),
        .i_data (w_side6),
        .o_data (w_side40)
    );

    // area = len * 2^s / 2^(FRAC_BITS + tri), saturated
    assign w_a2 = r_a1 >> r_a1_sh;

    always_ff @(posedge i_clk) begin
        r_a1    <= ASH_W'(w_len) << w_side40.s;
        r_a1_sh <= 5'(FRAC_BITS) + 5'(w_side40.is_tri);
        r_a2    <= (w_a2 > ASH_W'(AREA_MAX)) ? AREA_MAX : w_a2[AREA_W-1:0];
    end

    mfna_delay #(.WIDTH(AREA_W), .DEPTH(DIV_STEPS - 2)) u_area_dly (
        .i_clk  (i_clk),
        .i_data (r_a2),
        .o_data (w_area57)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        mfna_div_lane u_div (
            .i_clk    (i_clk),
            .i_r      (w_side40.r[i]),
            .i_len    (w_len),
            .i_neg    (w_side40.neg[i]),
            .o_normal (w_nrm[i])
        );
    end

    always_comb begin
        w_tail40.degen    = w_side40.degen;
        w_tail40.centroid = w_side40.centroid;
    end

    mfna_delay #(.WIDTH($bits(t_tail)), .DEPTH(DIV_STEPS)) u_tail_dly (
        .i_clk  (i_clk),
        .i_data (w_tail40),
        .o_data (w_tail57)
    );

    // drop normal and area of a degenerate face
    always_ff @(posedge i_clk) begin
        r_out_nx    <= w_tail57.degen ? '0 : w_nrm[0];
        r_out_ny    <= w_tail57.degen ? '0 : w_nrm[1];
        r_out_nz    <= w_tail57.degen ? '0 : w_nrm[2];
        r_out_area  <= w_tail57.degen ? '0 : w_area57;
        r_out_cx    <= w_tail57.centroid[0];
        r_out_cy    <= w_tail57.centroid[1];
        r_out_cz    <= w_tail57.centroid[2];
        r_out_degen <= w_tail57.degen;
    end

    assign o_valid      = r_vld[LAT-1];
    assign o_normal_x   = r_out_nx;
    assign o_normal_y   = r_out_ny;
    assign o_normal_z   = r_out_nz;
    assign o_face_area  = r_out_area;
    assign o_centroid_x = r_out_cx;
    assign o_centroid_y = r_out_cy;
    assign o_centroid_z = r_out_cz;
    assign o_degenerate = r_out_degen;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##58 o_valid)
        else $error("result strobe missing after transfer");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0 &&
             o_face_area == '0))
        else $error("degenerate face with non-zero normal or area");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_degenerate) |->
            (o_normal_x <= 18'sd65536 && o_normal_x >= -18'sd65536 &&
             o_normal_y <= 18'sd65536 && o_normal_y >= -18'sd65536 &&
             o_normal_z <= 18'sd65536 && o_normal_z >= -18'sd65536))
        else $error("normal component outside unit range");

endmodule
